FILE: sv/cedec_pkg.sv
// Shared types and constants for the C-escape UTF-8 character decoder.
`default_nettype none

package cedec_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_UTF = 2'd1;
	localparam logic [1:0] ST_BAD_CP  = 2'd2;
	localparam logic [1:0] ST_BAD_ESC = 2'd3;

	localparam logic [31:0] REPLACEMENT_CP = 32'h0000_fffd;
	localparam logic [7:0]  BACKSLASH      = 8'h5c;

	// Input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	// Output beat
	typedef struct packed {
		logic [31:0] code_point;
		logic [1:0]  status;
		logic        final_result;
	} out_item_t;

	// Results of one decoded byte, handed to the result queue
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} cedec_push_t;

endpackage

`default_nettype wire

FILE: sv/cedec_core.sv
// Input register, decoder state and per-byte decode logic.
`default_nettype none

module cedec_core
	import cedec_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        escapes_enable,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire in_item_t    src_item,
	input  wire logic        room,
	output cedec_push_t      push
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_UTF8 = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_ESC  = 3'd3;
	localparam logic [2:0] PH_OCT  = 3'd4;
	localparam logic [2:0] PH_HEX  = 3'd5;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        take;
	logic [2:0]  phase_q;
	logic [31:0] acc_q;
	logic [1:0]  rem_q;

	logic [2:0]  phase_n;
	logic [31:0] acc_n;
	logic [1:0]  rem_n;
	out_item_t   res0, res1, res2;
	logic        v0, v1, v2;

	function automatic out_item_t mk(input logic [31:0] cp, input logic [1:0] st);
		out_item_t r;
		r.code_point   = cp;
		r.status       = st;
		r.final_result = 1'b0;
		return r;
	endfunction

	// Range check on a completed UTF-8 value
	function automatic out_item_t mk_checked(input logic [31:0] cp);
		out_item_t r;
		if ((cp >= 32'h0000_d800 && cp <= 32'h0000_dfff) || cp > 32'h0010_ffff) begin
			r = mk(REPLACEMENT_CP, ST_BAD_CP);
		end else begin
			r = mk(cp, ST_OK);
		end
		return r;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, b[3:0]};
		end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// {is_simple, value}
	function automatic logic [8:0] simple_esc(input logic [7:0] b);
		logic [8:0] r;
		case (b)
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			8'h5c: r = {1'b1, 8'h5c};
			8'h3f: r = {1'b1, 8'h3f};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0c};
			8'h6e: r = {1'b1, 8'h0a};
			8'h72: r = {1'b1, 8'h0d};
			8'h74: r = {1'b1, 8'h09};
			8'h76: r = {1'b1, 8'h0b};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Input register: holds a beat until the result queue has room for two
	assign take      = valid_s1 && room;
	assign src_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	// Decode: pending character, then restart on the same byte, then flush
	always_comb begin
		logic [7:0]  b;
		logic        cont;
		logic        redo;
		logic [31:0] acc_sh;
		logic [1:0]  rem_dec;
		logic [4:0]  hx;
		logic [8:0]  se;
		logic [2:0]  ph1;
		logic [31:0] acc1;
		logic [1:0]  rem1;

		b       = item_s1.text_byte;
		cont    = (b[7:6] == 2'b10);
		redo    = 1'b0;
		acc_sh  = {acc_q[25:0], b[5:0]};
		rem_dec = (rem_q != 2'd0) ? rem_q - 2'd1 : 2'd0;
		hx      = hex_digit(b);
		se      = simple_esc(b);
		ph1     = phase_q;
		acc1    = acc_q;
		rem1    = rem_q;
		v0      = 1'b0;
		v1      = 1'b0;
		v2      = 1'b0;
		res0    = mk(REPLACEMENT_CP, ST_BAD_UTF);
		res1    = mk({24'd0, b}, ST_OK);
		res2    = mk(acc_q, ST_OK);

		// Pending character
		case (phase_q)
			PH_UTF8: begin
				if (cont) begin
					if (rem_dec == 2'd0) begin
						v0   = 1'b1;
						res0 = mk_checked(acc_sh);
						ph1  = PH_IDLE;
						acc1 = '0;
						rem1 = 2'd0;
					end else begin
						acc1 = acc_sh;
						rem1 = rem_dec;
					end
				end else begin
					v0   = 1'b1;
					redo = 1'b1;
				end
			end
			PH_SKIP: begin
				if (!cont) begin
					v0   = 1'b1;
					redo = 1'b1;
				end
			end
			PH_ESC: begin
				if (b inside {[8'h30:8'h37]}) begin
					ph1  = PH_OCT;
					acc1 = {29'd0, b[2:0]};
				end else if (b == 8'h78) begin
					ph1  = PH_HEX;
					acc1 = '0;
				end else if (se[8]) begin
					v0   = 1'b1;
					res0 = mk({24'd0, se[7:0]}, ST_OK);
					ph1  = PH_IDLE;
					acc1 = '0;
				end else begin
					v0   = 1'b1;
					res0 = mk({24'd0, BACKSLASH}, ST_BAD_ESC);
					redo = 1'b1;
				end
			end
			PH_OCT: begin
				if (b inside {[8'h30:8'h37]}) begin
					acc1 = {acc_q[28:0], b[2:0]};
				end else begin
					v0   = 1'b1;
					res0 = mk(acc_q, ST_OK);
					redo = 1'b1;
				end
			end
			PH_HEX: begin
				if (hx[4]) begin
					acc1 = {acc_q[27:0], hx[3:0]};
				end else begin
					v0   = 1'b1;
					res0 = mk(acc_q, ST_OK);
					redo = 1'b1;
				end
			end
			default: begin
				redo = 1'b1;
			end
		endcase

		// Byte starts a new character
		if (redo) begin
			ph1  = PH_IDLE;
			acc1 = '0;
			rem1 = 2'd0;
			if (escapes_enable && b == BACKSLASH) begin
				ph1 = PH_ESC;
			end else if (b <= 8'h7f) begin
				v1 = 1'b1;
			end else if (b < 8'hc0) begin
				ph1 = PH_SKIP;
			end else if (b < 8'he0) begin
				ph1  = PH_UTF8;
				acc1 = {27'd0, b[4:0]};
				rem1 = 2'd1;
			end else if (b < 8'hf0) begin
				ph1  = PH_UTF8;
				acc1 = {28'd0, b[3:0]};
				rem1 = 2'd2;
			end else if (b < 8'hf8) begin
				ph1  = PH_UTF8;
				acc1 = {29'd0, b[2:0]};
				rem1 = 2'd3;
			end else begin
				ph1 = PH_SKIP;
			end
		end

		// End-of-text flush
		phase_n = ph1;
		acc_n   = acc1;
		rem_n   = rem1;
		if (item_s1.end_of_text) begin
			case (ph1)
				PH_UTF8, PH_SKIP: begin
					v2   = 1'b1;
					res2 = mk(REPLACEMENT_CP, ST_BAD_UTF);
				end
				PH_ESC: begin
					v2   = 1'b1;
					res2 = mk({24'd0, BACKSLASH}, ST_OK);
				end
				PH_OCT, PH_HEX: begin
					v2   = 1'b1;
					res2 = mk(acc1, ST_OK);
				end
				default: begin
					v2 = 1'b0;
				end
			endcase
			phase_n = PH_IDLE;
			acc_n   = '0;
			rem_n   = 2'd0;
		end
	end

	// Pack up to two results in order, mark the last one on end of text
	always_comb begin
		logic [1:0] n;
		n            = 2'(v0) + 2'(v1) + 2'(v2);
		push.count   = take ? n : 2'd0;
		push.first   = v0 ? res0 : (v1 ? res1 : res2);
		push.second  = (v0 && v1) ? res1 : res2;
		if (item_s1.end_of_text) begin
			if (n == 2'd2) begin
				push.second.final_result = 1'b1;
			end else begin
				push.first.final_result = 1'b1;
			end
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			rem_q   <= 2'd0;
		end else if (take) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			rem_q   <= rem_n;
		end
	end

endmodule

`default_nettype wire

FILE: sv/cedec_fifo.sv
// Result queue: takes up to two results per cycle, gives one per cycle while res_stall is low.
`default_nettype none

module cedec_fifo
	import cedec_pkg::*;
#(
	parameter int DEPTH = 4
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cedec_push_t push,
	output logic             room,
	output logic             res_valid,
	input  wire logic        res_stall,
	output out_item_t        res_item
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	out_item_t         mem [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              pop;
	logic [PtrW-1:0]   wr_ptr_1;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1  = nxt(wr_ptr_q);
	assign res_valid = (count_q != '0);
	assign res_item  = mem[rd_ptr_q];
	assign pop       = res_valid && !res_stall;
	// room for a two-result beat
	assign room      = (count_q <= CntW'(DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_1] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.count == 2'd1) begin
				wr_ptr_q <= wr_ptr_1;
			end else if (push.count == 2'd2) begin
				wr_ptr_q <= nxt(wr_ptr_1);
			end
			if (pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: sv/c_escape_utf8_char_decoder_top.sv
// Top level of the C-escape UTF-8 character decoder.
// An accepted byte is held in the input register and decoded; its results
// go to the result queue. Throughput: one byte per cycle while the queue
// has room for two results; two-result bytes can fill it and stall src.
// Reset (arst_n low): decoder idle, queue empty, escapes_enable set to 1.
`default_nettype none

module c_escape_utf8_char_decoder_top
	import cedec_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
)
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire in_item_t  src_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output out_item_t      res_item,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic      cfg_data
);

	logic        escapes_enable_q;
	logic        room;
	cedec_push_t push;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escapes_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			escapes_enable_q <= cfg_data;
		end
	end

	cedec_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.escapes_enable (escapes_enable_q),
		.src_valid      (src_valid),
		.src_stall      (src_stall),
		.src_item       (src_item),
		.room           (room),
		.push           (push)
	);

	cedec_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

FILE: sv/cedec_checker.sv
// Port-level checks for the decoder top and their bind.
`default_nettype none

module cedec_checker
	import cedec_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      src_valid,
	input wire logic      src_stall,
	input wire in_item_t  src_item,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire out_item_t res_item
);

	// A stalled input beat holds
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_item))
		else $error("input beat changed while stalled");

	// A stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result beat changed while stalled");

	// With nothing queued the input side never stalls
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !src_stall)
		else $error("input stalled with empty result queue");

	// Bad UTF-8 and bad code points always carry the replacement character
	a_bad_utf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.status == ST_BAD_UTF || res_item.status == ST_BAD_CP)
		|-> res_item.code_point == REPLACEMENT_CP)
		else $error("error status without U+FFFD");

	// An illegal escape gives a backslash
	a_bad_esc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == ST_BAD_ESC
		|-> res_item.code_point == {24'd0, BACKSLASH})
		else $error("illegal escape without backslash");

endmodule

bind c_escape_utf8_char_decoder_top cedec_checker u_cedec_checker (.*);

`default_nettype wire

FILE: tb/sv/c_escape_utf8_char_decoder_top_tb.sv
// Testbench for the C-escape UTF-8 character decoder: directed and random byte streams.
`timescale 1ns / 100ps

module c_escape_utf8_char_decoder_top_tb;
	import cedec_pkg::*;

	// Decoder phases of the checker's own model
	typedef enum logic [2:0] {
		DP_IDLE = 3'd0,
		DP_UTF8 = 3'd1,
		DP_SKIP = 3'd2,
		DP_ESC  = 3'd3,
		DP_OCT  = 3'd4,
		DP_HEX  = 3'd5
	} dec_phase_t;

	localparam logic [7:0] CH_X = 8'h78;

	// Tracks decoder state per accepted byte and holds the code points still owed
	class decode_checker;
		logic       esc_on;
		dec_phase_t phase;
		logic [31:0] acc;
		logic [1:0]  remaining;
		out_item_t   pending_chars[$];
		int          step_results;
		int          fail_count;

		function new();
			esc_on = 1'b1;
			fail_count = 0;
			go_idle();
		endfunction

		function void go_idle();
			phase = DP_IDLE;
			acc = '0;
			remaining = '0;
		endfunction

		function void owe(logic [31:0] cp, logic [1:0] st);
			out_item_t r;
			r.code_point = cp;
			r.status = st;
			r.final_result = 1'b0;
			pending_chars.push_back(r);
			step_results++;
		endfunction

		// Surrogates and values past U+10FFFF become the replacement char
		function void owe_scalar(logic [31:0] cp);
			if ((cp >= 32'hd800 && cp <= 32'hdfff) || cp > 32'h0010_ffff)
				owe(REPLACEMENT_CP, ST_BAD_CP);
			else
				owe(cp, ST_OK);
		endfunction

		// {valid, digit value}
		function logic [4:0] hex_digit(logic [7:0] b);
			if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
			if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
			if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
			return 5'd0;
		endfunction

		// {valid, value} of a one-char escape
		function logic [8:0] simple_escape(logic [7:0] b);
			case (b)
				8'h27: return {1'b1, 8'h27};
				8'h22: return {1'b1, 8'h22};
				8'h5c: return {1'b1, 8'h5c};
				8'h3f: return {1'b1, 8'h3f};
				8'h61: return {1'b1, 8'h07};
				8'h62: return {1'b1, 8'h08};
				8'h66: return {1'b1, 8'h0c};
				8'h6e: return {1'b1, 8'h0a};
				8'h72: return {1'b1, 8'h0d};
				8'h74: return {1'b1, 8'h09};
				8'h76: return {1'b1, 8'h0b};
				default: return 9'd0;
			endcase
		endfunction

		// Advance the model by one accepted input beat
		function void decode_byte(in_item_t beat);
			logic [7:0] b;
			logic       cont;
			logic       again;
			logic [4:0] hd;
			logic [8:0] se;
			out_item_t  last;
			b = beat.text_byte;
			step_results = 0;
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				cont = (b[7:6] == 2'b10);
				case (phase)
					DP_UTF8: begin
						if (cont) begin
							acc = {acc[25:0], b[5:0]};
							if (remaining != 2'd0)
								remaining = remaining - 2'd1;
							if (remaining == 2'd0) begin
								owe_scalar(acc);
								go_idle();
							end
						end else begin
							// truncated sequence; this byte starts a new char
							owe(REPLACEMENT_CP, ST_BAD_UTF);
							go_idle();
							again = 1'b1;
						end
					end
					DP_SKIP: begin
						if (!cont) begin
							owe(REPLACEMENT_CP, ST_BAD_UTF);
							go_idle();
							again = 1'b1;
						end
					end
					DP_ESC: begin
						se = simple_escape(b);
						if (b >= 8'h30 && b <= 8'h37) begin
							acc = {29'd0, b[2:0]};
							phase = DP_OCT;
						end else if (b == CH_X) begin
							acc = '0;
							phase = DP_HEX;
						end else if (se[8]) begin
							owe({24'd0, se[7:0]}, ST_OK);
							go_idle();
						end else begin
							owe({24'd0, BACKSLASH}, ST_BAD_ESC);
							go_idle();
							again = 1'b1;
						end
					end
					DP_OCT: begin
						if (b >= 8'h30 && b <= 8'h37) begin
							acc = {acc[28:0], b[2:0]};
						end else begin
							owe(acc, ST_OK);
							go_idle();
							again = 1'b1;
						end
					end
					DP_HEX: begin
						hd = hex_digit(b);
						if (hd[4]) begin
							acc = {acc[27:0], hd[3:0]};
						end else begin
							owe(acc, ST_OK);
							go_idle();
							again = 1'b1;
						end
					end
					default: begin
						go_idle();
						if (esc_on && b == BACKSLASH) begin
							phase = DP_ESC;
						end else if (b <= 8'h7f) begin
							owe({24'd0, b}, ST_OK);
						end else if (b < 8'hc0) begin
							phase = DP_SKIP;
						end else if (b < 8'he0) begin
							acc = {27'd0, b[4:0]};
							remaining = 2'd1;
							phase = DP_UTF8;
						end else if (b < 8'hf0) begin
							acc = {28'd0, b[3:0]};
							remaining = 2'd2;
							phase = DP_UTF8;
						end else if (b < 8'hf8) begin
							acc = {29'd0, b[2:0]};
							remaining = 2'd3;
							phase = DP_UTF8;
						end else begin
							phase = DP_SKIP;
						end
					end
				endcase
			end

			// end of text flushes whatever is pending and tags the last result
			if (beat.end_of_text) begin
				case (phase)
					DP_UTF8, DP_SKIP: owe(REPLACEMENT_CP, ST_BAD_UTF);
					DP_ESC:           owe({24'd0, BACKSLASH}, ST_OK);
					DP_OCT, DP_HEX:   owe(acc, ST_OK);
					default: ;
				endcase
				go_idle();
				if (step_results > 0) begin
					last = pending_chars.pop_back();
					last.final_result = 1'b1;
					pending_chars.push_back(last);
				end
			end
		endfunction

		// Compare one accepted output beat with the oldest owed result
		function void check_char(out_item_t got);
			out_item_t want;
			if (pending_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result cp=%h st=%0d fin=%0b",
						$time, got.code_point, got.status, got.final_result);
				return;
			end
			want = pending_chars.pop_front();
			if (got.code_point !== want.code_point || got.status !== want.status ||
					got.final_result !== want.final_result) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: mismatch exp cp=%h st=%0d fin=%0b got cp=%h st=%0d fin=%0b",
						$time, want.code_point, want.status, want.final_result,
						got.code_point, got.status, got.final_result);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_item_t  src_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_item_t res_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	int src_idle_pct = 0;
	int res_idle_pct = 0;
	int bytes_sent = 0;

	decode_checker board = new();

	logic [7:0] opening_bytes [26] = '{
		8'hc3, 8'ha9,               // two-byte char
		8'hed, 8'ha0, 8'h80,        // surrogate
		8'hf4, 8'h90, 8'h80, 8'h80, // above U+10FFFF
		8'he2, 8'h00,               // truncated, then NUL
		8'hbf, 8'h80, 8'hff,        // stray run, then bad lead
		8'h5c, 8'h6e,               // newline escape
		8'h5c, 8'h37, 8'h37, 8'h78, // octal ended by a plain char
		8'h5c, 8'h78, 8'h67,        // empty hex
		8'h5c, 8'h71,               // illegal escape
		8'h5c                       // trailing backslash at end of text
	};

	c_escape_utf8_char_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_char(res_item);
		res_stall <= ($urandom_range(99) < res_idle_pct);
	end

	// Hands one byte to the block and waits until the beat is taken
	task automatic send_byte(logic [7:0] b, logic eot);
		in_item_t beat;
		beat.text_byte = b;
		beat.end_of_text = eot;
		// idle cycles drawn one at a time at the sender's idle rate
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= beat;
		do @(posedge clk); while (src_stall);
		board.decode_byte(beat);
		bytes_sent++;
	endtask

	// Random end of text now and then, so pending chars get flushed anywhere
	task automatic send_text(logic [7:0] b);
		send_byte(b, $urandom_range(99) < 3);
	endtask

	// Stop sending until every owed result has come out, then let the pipe settle
	task automatic wait_idle();
		src_valid <= 1'b0;
		while (board.pending_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_escapes(logic en);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.esc_on = en;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] hex_char();
		int d;
		d = $urandom_range(0, 21);
		if (d < 10) return 8'h30 + 8'(d);
		if (d < 16) return 8'h61 + 8'(d - 10);
		return 8'h41 + 8'(d - 16);
	endfunction

	function automatic logic [7:0] simple_char();
		case ($urandom_range(0, 10))
			0: return 8'h27;
			1: return 8'h22;
			2: return 8'h5c;
			3: return 8'h3f;
			4: return 8'h61;
			5: return 8'h62;
			6: return 8'h66;
			7: return 8'h6e;
			8: return 8'h72;
			9: return 8'h74;
			default: return 8'h76;
		endcase
	endfunction

	// One random character: mostly well formed, some broken, some noise
	task automatic send_random_char();
		int kind;
		int len;
		kind = $urandom_range(0, 99);
		if (kind < 18) begin
			send_text(8'($urandom_range(0, 127)));
		end else if (kind < 30) begin
			send_text(8'hc0 | 8'($urandom_range(0, 31)));
			send_text(cont_byte());
		end else if (kind < 42) begin
			send_text(($urandom_range(0, 3) == 0) ? 8'hed : (8'he0 | 8'($urandom_range(0, 15))));
			repeat (2) send_text(cont_byte());
		end else if (kind < 52) begin
			send_text(8'hf0 | 8'($urandom_range(0, 7)));
			repeat (3) send_text(cont_byte());
		end else if (kind < 62) begin
			send_text(BACKSLASH);
			send_text(simple_char());
		end else if (kind < 70) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 3);
			send_text(BACKSLASH);
			repeat (len) send_text(8'h30 + 8'($urandom_range(0, 7)));
		end else if (kind < 78) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
			send_text(BACKSLASH);
			send_text(CH_X);
			repeat (len) send_text(hex_char());
		end else if (kind < 84) begin
			send_text(BACKSLASH);
			send_text(8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			// lead byte followed by zero to two continuation bytes, often too few
			len = $urandom_range(0, 2);
			send_text(8'hc0 | 8'($urandom_range(0, 55)));
			repeat (len) send_text(cont_byte());
		end else if (kind < 95) begin
			send_text(($urandom_range(0, 1) == 0) ? cont_byte() : (8'hf8 | 8'($urandom_range(0, 7))));
			repeat ($urandom_range(0, 3)) send_text(cont_byte());
		end else begin
			send_text(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(int count);
		int stop_at;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			send_random_char();
			if ($urandom_range(0, 199) == 0)
				wait_idle();
		end
	endtask

	// Main sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_escapes(1'b1);

		// directed text, last byte ends the text
		for (int i = 0; i < 26; i++)
			send_byte(opening_bytes[i], i == 25);

		// turning escapes off after a backslash must not break that escape
		wait_idle();
		send_byte(BACKSLASH, 1'b0);
		wait_idle();
		write_escapes(1'b0);
		send_byte(8'h6e, 1'b0);
		send_byte(BACKSLASH, 1'b0);
		send_byte(8'h7f, 1'b1);
		wait_idle();
		write_escapes(1'b1);

		src_idle_pct = 26;
		res_idle_pct = 54;
		run_random(470);

		wait_idle();
		write_escapes(1'b0);
		src_idle_pct = 54;
		res_idle_pct = 26;
		run_random(470);

		wait_idle();
		write_escapes(1'b1);
		src_idle_pct = 0;
		res_idle_pct = 0;
		run_random(470);

		wait_idle();
		if (board.fail_count == 0 && board.pending_chars.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
sv/cedec_pkg.sv
sv/cedec_core.sv
sv/cedec_fifo.sv
sv/c_escape_utf8_char_decoder_top.sv
sv/cedec_checker.sv
tb/sv/c_escape_utf8_char_decoder_top_tb.sv
